// ===== sv/twdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package twdt_pkg;

  localparam int ADDR_W          = 48;
  localparam int TIME_W          = 32;
  localparam int SLOT_W          = 8;
  localparam int DEFAULT_ENTRIES = 256;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd30000;

  typedef enum logic [1:0] {
    OUTCOME_SUPPRESSED = 2'd0,
    OUTCOME_REFRESHED  = 2'd1,
    OUTCOME_INSERTED   = 2'd2,
    OUTCOME_REPLACED   = 2'd3
  } outcome_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ===== sv/twdt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module twdt_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  output logic                    busy,
  input  twdt_pkg::ctrl_status_t  status,
  output twdt_pkg::ctrl_cmd_t     cmd
);
  import twdt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/twdt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module twdt_datapath #(
  parameter int ENTRIES = twdt_pkg::DEFAULT_ENTRIES
) (
  input  wire                             clk,
  input  wire                             rst,
  input  twdt_pkg::ctrl_cmd_t             cmd,
  output twdt_pkg::ctrl_status_t          status,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [twdt_pkg::TIME_W-1:0]     window_ms,
  input  wire  [twdt_pkg::ADDR_W-1:0]     mac_address,
  input  wire  [twdt_pkg::TIME_W-1:0]     now_ms,
  output logic                            result_valid,
  output logic                            emit,
  output logic [1:0]                      outcome,
  output logic [twdt_pkg::SLOT_W-1:0]     slot_index
);
  import twdt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  logic [ADDR_W-1:0] mem_addr [ENTRIES];
  logic [TIME_W-1:0] mem_time [ENTRIES];

  logic [TIME_W-1:0] window_q;
  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] key_addr;
  logic [TIME_W-1:0] key_now;
  logic [CNT_W-1:0]  issue_cnt;
  logic              pipe_vld;
  logic [IDX_W-1:0]  pipe_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [TIME_W-1:0] rd_time;
  logic              hit;
  logic              hit_fresh;
  logic [IDX_W-1:0]  hit_idx;
  logic              victim_vld;
  logic [IDX_W-1:0]  victim_idx;
  logic [TIME_W-1:0] victim_time;

  logic              issue;
  logic [TIME_W-1:0] age;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  outcome_t          dec_outcome;
  logic [CNT_W-1:0]  fill_next;

  assign cfg_ready = 1'b1;

  assign issue  = cmd.scan && !hit && (issue_cnt != fill);
  assign age    = key_now - rd_time;
  assign status.scan_done = hit || ((issue_cnt == fill) && !pipe_vld);

  always_comb begin
    wr_en       = 1'b1;
    wr_idx      = hit_idx;
    fill_next   = fill;
    dec_outcome = OUTCOME_REFRESHED;
    if (hit) begin
      if (hit_fresh) begin
        wr_en       = 1'b0;
        dec_outcome = OUTCOME_SUPPRESSED;
      end
    end else if (fill != FULL) begin
      wr_idx      = fill[IDX_W-1:0];
      fill_next   = fill + CNT_W'(1);
      dec_outcome = OUTCOME_INSERTED;
    end else begin
      wr_idx      = victim_idx;
      dec_outcome = OUTCOME_REPLACED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem_addr[wr_idx] <= key_addr;
      mem_time[wr_idx] <= key_now;
    end
    if (issue) begin
      rd_addr <= mem_addr[issue_cnt[IDX_W-1:0]];
      rd_time <= mem_time[issue_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_q     <= WINDOW_RESET;
      fill         <= '0;
      result_valid <= 1'b0;
      pipe_vld     <= 1'b0;
      hit          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_q <= window_ms;
      end
      result_valid <= cmd.commit;
      if (cmd.commit) begin
        fill <= fill_next;
      end
      if (cmd.load) begin
        pipe_vld <= 1'b0;
        hit      <= 1'b0;
      end else if (cmd.scan) begin
        pipe_vld <= issue;
        if (pipe_vld && !hit && (rd_addr == key_addr)) begin
          hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_addr   <= mac_address;
      key_now    <= now_ms;
      issue_cnt  <= '0;
      victim_vld <= 1'b0;
    end else if (cmd.scan) begin
      if (issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
        pipe_idx  <= issue_cnt[IDX_W-1:0];
      end
      if (pipe_vld && !hit) begin
        if (rd_addr == key_addr) begin
          hit_idx   <= pipe_idx;
          hit_fresh <= (age < window_q);
        end else if (!victim_vld || (rd_time < victim_time)) begin
          victim_vld  <= 1'b1;
          victim_idx  <= pipe_idx;
          victim_time <= rd_time;
        end
      end
    end
    if (cmd.commit) begin
      emit       <= (dec_outcome != OUTCOME_SUPPRESSED);
      outcome    <= dec_outcome;
      slot_index <= SLOT_W'(wr_idx);
    end
  end

endmodule

`default_nettype wire

// ===== sv/time_window_dedup_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Duplicate filter for station sightings over a time window.
// Command channel: present mac_address and now_ms with start; the item is
// taken at a clock edge where start is high and busy is low.
// The table fills from entry 0 upward, so a fill count stands for the valid
// bits. A lookup walks the filled entries through the single memory read
// port, one entry per cycle, and stops at the matching entry on a hit; the
// compare comes in the cycle after the read. One item is in flight at a
// time, and the next is taken at the edge that ends the result cycle.
// Result: emit, outcome and slot_index are valid for the one cycle that
// result_valid is high; the receiver cannot stall, and busy is already
// low in that cycle, so the next item may be taken there.
// Configuration: window_ms is written at an edge where cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Reset (synchronous, rst high) empties the table at once and sets the
// window to 30000 ms.

module time_window_dedup_table #(
  parameter int ENTRIES = twdt_pkg::DEFAULT_ENTRIES
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire  [twdt_pkg::ADDR_W-1:0]     mac_address,
  input  wire  [twdt_pkg::TIME_W-1:0]     now_ms,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [twdt_pkg::TIME_W-1:0]     window_ms,
  output logic                            result_valid,
  output logic                            emit,
  output logic [1:0]                      outcome,
  output logic [twdt_pkg::SLOT_W-1:0]     slot_index
);
  import twdt_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  twdt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  twdt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_ms    (window_ms),
    .mac_address  (mac_address),
    .now_ms       (now_ms),
    .result_valid (result_valid),
    .emit         (emit),
    .outcome      (outcome),
    .slot_index   (slot_index)
  );

endmodule

`default_nettype wire

// ===== verif/tb_time_window_dedup_table.sv =====
`timescale 1ns / 1ps

module tb_time_window_dedup_table;
  import twdt_pkg::*;

  localparam int ENT = DEFAULT_ENTRIES;
  localparam int POOL_SIZE = 320;
  localparam int HOT_SIZE = 8;
  localparam int PHASES = 6;
  localparam int PER_PHASE = 272;
  localparam int DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic emit;
    outcome_t outcome;
    logic [SLOT_W-1:0] slot;
  } verdict_t;

  typedef enum logic {ROW_SIGHTING, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [ADDR_W-1:0] mac;
    logic [TIME_W-1:0] value;
    logic typed;
    verdict_t verdict;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [ADDR_W-1:0] mac_address;
  logic [TIME_W-1:0] now_ms;
  logic cfg_valid;
  logic cfg_ready;
  logic [TIME_W-1:0] window_ms;
  logic result_valid;
  logic emit;
  logic [1:0] outcome;
  logic [SLOT_W-1:0] slot_index;

  time_window_dedup_table uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mac_address(mac_address),
    .now_ms(now_ms),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .window_ms(window_ms),
    .result_valid(result_valid),
    .emit(emit),
    .outcome(outcome),
    .slot_index(slot_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the table
  bit tbl_valid [ENT];
  logic [ADDR_W-1:0] tbl_addr [ENT];
  logic [TIME_W-1:0] tbl_seen [ENT];
  logic [TIME_W-1:0] win_setting;

  verdict_t expected_verdicts [$];
  verdict_t head;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  int idle_pct;
  int errors;
  int sightings;
  int windows_set;
  int outcome_hits [4];
  longint cycles;

  step_row_t directed_steps [0:19] = '{
    '{ROW_SIGHTING, 48'h0, 32'd0, 1'b1, '{1'b1, OUTCOME_INSERTED, 8'd0}},
    '{ROW_SIGHTING, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, OUTCOME_INSERTED, 8'd1}},
    '{ROW_SIGHTING, 48'h0, 32'd100, 1'b1, '{1'b0, OUTCOME_SUPPRESSED, 8'd0}},
    '{ROW_SIGHTING, 48'hFFFF_FFFF_FFFF, 32'd29998, 1'b1, '{1'b0, OUTCOME_SUPPRESSED, 8'd1}},
    '{ROW_SIGHTING, 48'hFFFF_FFFF_FFFF, 32'd29999, 1'b1, '{1'b1, OUTCOME_REFRESHED, 8'd1}},
    '{ROW_SIGHTING, 48'h0, 32'd30000, 1'b1, '{1'b1, OUTCOME_REFRESHED, 8'd0}},
    '{ROW_SIGHTING, 48'h5555_5555_5555, 32'd30000, 1'b1, '{1'b1, OUTCOME_INSERTED, 8'd2}},
    '{ROW_SIGHTING, 48'hAAAA_AAAA_AAAA, 32'd30000, 1'b1, '{1'b1, OUTCOME_INSERTED, 8'd3}},
    '{ROW_WINDOW, 48'h0, 32'd0, 1'b0, '{1'b0, OUTCOME_SUPPRESSED, 8'd0}},
    '{ROW_SIGHTING, 48'h0, 32'd30000, 1'b1, '{1'b1, OUTCOME_REFRESHED, 8'd0}},
    '{ROW_SIGHTING, 48'h5555_5555_5555, 32'd30000, 1'b1, '{1'b1, OUTCOME_REFRESHED, 8'd2}},
    '{ROW_WINDOW, 48'h0, 32'hFFFF_FFFF, 1'b0, '{1'b0, OUTCOME_SUPPRESSED, 8'd0}},
    '{ROW_SIGHTING, 48'h0, 32'd29999, 1'b1, '{1'b1, OUTCOME_REFRESHED, 8'd0}},
    '{ROW_SIGHTING, 48'h0, 32'd29999, 1'b1, '{1'b0, OUTCOME_SUPPRESSED, 8'd0}},
    '{ROW_SIGHTING, 48'hAAAA_AAAA_AAAA, 32'd30001, 1'b1, '{1'b0, OUTCOME_SUPPRESSED, 8'd3}},
    '{ROW_WINDOW, 48'h0, WINDOW_RESET, 1'b0, '{1'b0, OUTCOME_SUPPRESSED, 8'd0}},
    '{ROW_SIGHTING, 48'h0000_0000_0001, 32'd5, 1'b0, '{1'b0, OUTCOME_SUPPRESSED, 8'd0}},
    '{ROW_SIGHTING, 48'h8000_0000_0000, 32'h8000_0000, 1'b0, '{1'b0, OUTCOME_SUPPRESSED, 8'd0}},
    '{ROW_SIGHTING, 48'h0, 32'd60000, 1'b0, '{1'b0, OUTCOME_SUPPRESSED, 8'd0}},
    '{ROW_SIGHTING, 48'hFFFF_FFFF_FFFF, 32'd12345, 1'b0, '{1'b0, OUTCOME_SUPPRESSED, 8'd0}}
  };

  function automatic verdict_t judge_sighting(input logic [ADDR_W-1:0] mac,
                                              input logic [TIME_W-1:0] now);
    verdict_t v;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] oldest_seen;
    int oldest;
    oldest = 0;
    oldest_seen = '0;
    for (int i = 0; i < ENT; i++) begin
      if (tbl_valid[i] && tbl_addr[i] == mac) begin
        age = now - tbl_seen[i];
        v.slot = SLOT_W'(i);
        if (age < win_setting) begin
          v.emit = 1'b0;
          v.outcome = OUTCOME_SUPPRESSED;
        end else begin
          tbl_seen[i] = now;
          v.emit = 1'b1;
          v.outcome = OUTCOME_REFRESHED;
        end
        return v;
      end
    end
    for (int i = 0; i < ENT; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_addr[i] = mac;
        tbl_seen[i] = now;
        v.emit = 1'b1;
        v.outcome = OUTCOME_INSERTED;
        v.slot = SLOT_W'(i);
        return v;
      end
      if (i == 0 || tbl_seen[i] < oldest_seen) begin
        oldest = i;
        oldest_seen = tbl_seen[i];
      end
    end
    tbl_addr[oldest] = mac;
    tbl_seen[oldest] = now;
    v.emit = 1'b1;
    v.outcome = OUTCOME_REPLACED;
    v.slot = SLOT_W'(oldest);
    return v;
  endfunction

  task automatic issue_sighting(input logic [ADDR_W-1:0] mac, input logic [TIME_W-1:0] now,
                                input logic typed, input verdict_t typed_verdict);
    verdict_t v;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mac_address <= mac;
    now_ms <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    v = judge_sighting(mac, now);
    expected_verdicts.push_back(typed ? typed_verdict : v);
    sightings++;
  endtask

  task automatic write_window(input logic [TIME_W-1:0] value);
    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    window_ms <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_setting = value;
    windows_set++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected item emit=%0d outcome=%0d slot=%0d",
                 $time, emit, outcome, slot_index);
        errors++;
      end else begin
        head = expected_verdicts.pop_front();
        outcome_hits[head.outcome]++;
        if (emit !== head.emit) begin
          $display("%0t: emit expected %0d actual %0d", $time, head.emit, emit);
          errors++;
        end
        if (outcome !== head.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, head.outcome, outcome);
          errors++;
        end
        if (slot_index !== head.slot) begin
          $display("%0t: slot_index expected %0d actual %0d", $time, head.slot, slot_index);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, expected_verdicts.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0] raw;
    logic [ADDR_W-1:0] mac;
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] phase_window [PHASES];
    int phase_idle [PHASES];
    int unsigned step_max;
    int r;

    errors = 0;
    sightings = 0;
    windows_set = 0;
    cycles = 0;
    idle_pct = 0;
    foreach (outcome_hits[k]) outcome_hits[k] = 0;
    rst <= 1'b1;
    start <= 1'b0;
    mac_address <= '0;
    now_ms <= '0;
    cfg_valid <= 1'b0;
    window_ms <= '0;

    win_setting = WINDOW_RESET;
    for (int i = 0; i < ENT; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i] = '0;
      tbl_seen[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      raw = {$urandom, $urandom};
      addr_pool[i] = raw[ADDR_W-1:0];
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[k]) begin
      if (directed_steps[k].kind == ROW_WINDOW)
        write_window(directed_steps[k].value);
      else
        issue_sighting(directed_steps[k].mac, directed_steps[k].value,
                       directed_steps[k].typed, directed_steps[k].verdict);
    end

    phase_window = '{WINDOW_RESET, 32'd0, 32'hFFFF_FFFF,
                     TIME_W'($urandom_range(1, 5000)), TIME_W'($urandom), WINDOW_RESET};
    phase_idle = '{0, 74, 0, 29, 74, 29};
    clock_ms = 32'd100000;

    for (int p = 0; p < PHASES; p++) begin
      write_window(phase_window[p]);
      idle_pct = phase_idle[p];
      step_max = (win_setting == 0) ? 100 : (win_setting >> 3) + 1;
      // cross the timestamp wrap in the last phase
      if (p == PHASES - 1) clock_ms = 32'hFFFF_8000;
      for (int n = 0; n < PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          mac = addr_pool[$urandom_range(0, HOT_SIZE - 1)];
        end else if (r < 88) begin
          mac = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          raw = {$urandom, $urandom};
          mac = raw[ADDR_W-1:0];
        end
        r = $urandom_range(0, 99);
        if (r >= 25 && r < 80)
          clock_ms = clock_ms + $urandom_range(0, step_max);
        else if (r >= 80)
          clock_ms = clock_ms + 4 * $urandom_range(0, step_max);
        now = (r >= 95) ? TIME_W'($urandom) : clock_ms;
        issue_sighting(mac, now, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d sightings under %0d window settings, idle from 0 to 74 percent.",
             sightings, windows_set);
    $display("Outcomes: %0d suppressed, %0d refreshed, %0d inserted, %0d replaced oldest.",
             outcome_hits[OUTCOME_SUPPRESSED], outcome_hits[OUTCOME_REFRESHED],
             outcome_hits[OUTCOME_INSERTED], outcome_hits[OUTCOME_REPLACED]);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/twdt_pkg.sv
sv/twdt_ctrl.sv
sv/twdt_datapath.sv
sv/time_window_dedup_table.sv
verif/tb_time_window_dedup_table.sv
